// ===== design/sed_pkg.sv =====
// Shared types for the string escape decoder.
// Holds the mode and result-kind codes, the decoder state and the result word layout.
// No dependencies.
package sed_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_OCT    = 3'd2,
    MODE_HEX0   = 3'd3,
    MODE_HEX1   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] digit_value;
    logic [1:0] digit_count;
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  // Everything one raw byte produces: zero, one or two results.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } dec_t;

endpackage

// ===== design/sed_decode.sv =====
// Combinational escape decoder: one raw byte plus current state gives the next
// state and up to two results. Depends on sed_pkg.
module sed_decode (
  input  sed_pkg::state_t st,
  input  logic [7:0]      in_byte,
  output sed_pkg::state_t st_next,
  output sed_pkg::dec_t   dec
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;

  localparam sed_pkg::state_t ST_CLEAR = '{mode: sed_pkg::MODE_NORMAL,
                                           digit_value: 8'd0, digit_count: 2'd0};

  // Simple escape letters and their values; bit 8 flags a hit.
  function automatic logic [8:0] simple_esc(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0B};
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h27:   r = {1'b1, 8'h27};
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h3F:   r = {1'b1, 8'h3F};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Hex digit value; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic sed_pkg::result_t mk(input sed_pkg::kind_t k, input logic [7:0] b);
    sed_pkg::result_t r;
    r.kind = k;
    r.data = (k == sed_pkg::KIND_BYTE) ? b : 8'd0;
    r.last = 1'b0;
    return r;
  endfunction

  logic [8:0] esc_hit;
  logic [4:0] hex;
  logic       is_oct;
  logic [1:0] cnt_inc;
  logic [7:0] oct_val;
  // Plain-text handling of the byte: does it emit, what, and does it open an escape.
  logic              nrm_emit;
  sed_pkg::result_t  nrm_res;
  logic              nrm_esc;
  sed_pkg::dec_t     d;

  assign esc_hit = simple_esc(in_byte);
  assign hex     = hex_val(in_byte);
  assign is_oct  = (in_byte[7:3] == 5'b00110);
  assign cnt_inc = st.digit_count + 2'd1;
  assign oct_val = {st.digit_value[4:0], in_byte[2:0]};

  always_comb begin
    nrm_emit = 1'b1;
    nrm_esc  = 1'b0;
    priority if (in_byte == CH_NUL) begin
      nrm_res = mk(sed_pkg::KIND_ERR, 8'd0);
    end else if (in_byte == CH_QUOTE) begin
      nrm_res = mk(sed_pkg::KIND_END, 8'd0);
    end else if (in_byte == CH_BSLASH) begin
      nrm_res  = mk(sed_pkg::KIND_BYTE, 8'd0);
      nrm_emit = 1'b0;
      nrm_esc  = 1'b1;
    end else begin
      nrm_res = mk(sed_pkg::KIND_BYTE, in_byte);
    end
  end

  // Next state.
  always_comb begin
    st_next = st;
    unique case (st.mode)
      sed_pkg::MODE_ESC: begin
        st_next = ST_CLEAR;
        // A zero escape is complete at once; other octal digits open a numeric escape.
        priority if (is_oct && in_byte != CH_ZERO) begin
          st_next.mode        = sed_pkg::MODE_OCT;
          st_next.digit_value = {5'd0, in_byte[2:0]};
          st_next.digit_count = 2'd1;
        end else if (in_byte == CH_X) begin
          st_next.mode = sed_pkg::MODE_HEX0;
        end else begin
          st_next.mode = sed_pkg::MODE_NORMAL;
        end
      end
      sed_pkg::MODE_OCT: begin
        if (is_oct) begin
          if (cnt_inc == 2'd3) begin
            st_next = ST_CLEAR;
          end else begin
            st_next.digit_value = oct_val;
            st_next.digit_count = cnt_inc;
          end
        end else begin
          st_next = ST_CLEAR;
          if (nrm_esc) st_next.mode = sed_pkg::MODE_ESC;
        end
      end
      sed_pkg::MODE_HEX0: begin
        if (hex[4]) begin
          st_next.mode        = sed_pkg::MODE_HEX1;
          st_next.digit_value = {4'd0, hex[3:0]};
          st_next.digit_count = 2'd1;
        end else begin
          st_next = ST_CLEAR;
        end
      end
      sed_pkg::MODE_HEX1: begin
        st_next = ST_CLEAR;
        if (!hex[4] && nrm_esc) st_next.mode = sed_pkg::MODE_ESC;
      end
      default: begin
        // Normal text; unused mode codes behave the same way.
        st_next = ST_CLEAR;
        if (nrm_esc) st_next.mode = sed_pkg::MODE_ESC;
      end
    endcase
  end

  // Results.
  always_comb begin
    d = '0;
    unique case (st.mode)
      sed_pkg::MODE_ESC: begin
        d.count = 2'd1;
        priority if (in_byte == CH_NUL) begin
          d.res0 = mk(sed_pkg::KIND_ERR, 8'd0);
        end else if (esc_hit[8]) begin
          d.res0 = mk(sed_pkg::KIND_BYTE, esc_hit[7:0]);
        end else if (in_byte == CH_ZERO) begin
          d.res0 = mk(sed_pkg::KIND_BYTE, 8'd0);
        end else if (is_oct || in_byte == CH_X) begin
          d.count = 2'd0;
        end else begin
          d.res0 = mk(sed_pkg::KIND_BYTE, in_byte);
        end
      end
      sed_pkg::MODE_OCT: begin
        if (is_oct) begin
          if (cnt_inc == 2'd3) begin
            d.count = 2'd1;
            d.res0  = mk(sed_pkg::KIND_BYTE, oct_val);
          end
        end else begin
          // Flush the pending value, then treat the byte as plain text.
          d.res0  = mk(sed_pkg::KIND_BYTE, st.digit_value);
          d.res1  = nrm_res;
          d.count = nrm_emit ? 2'd2 : 2'd1;
        end
      end
      sed_pkg::MODE_HEX0: begin
        if (!hex[4]) begin
          d.count = 2'd1;
          d.res0  = mk(sed_pkg::KIND_ERR, 8'd0);
        end
      end
      sed_pkg::MODE_HEX1: begin
        if (hex[4]) begin
          d.count = 2'd1;
          d.res0  = mk(sed_pkg::KIND_BYTE, {st.digit_value[3:0], hex[3:0]});
        end else begin
          d.res0  = mk(sed_pkg::KIND_BYTE, st.digit_value);
          d.res1  = nrm_res;
          d.count = nrm_emit ? 2'd2 : 2'd1;
        end
      end
      default: begin
        d.res0  = nrm_res;
        d.count = nrm_emit ? 2'd1 : 2'd0;
      end
    endcase
    if (d.count == 2'd1) d.res0.last = 1'b1;
    if (d.count == 2'd2) d.res1.last = 1'b1;
    dec = d;
  end

endmodule

// ===== design/string_escape_decoder.sv =====
// Top level of the C string escape decoder: input register, decode state and
// a four-word result queue. Depends on sed_pkg and sed_decode.
//
//  channel | direction | tdata           | tuser         | tlast
//  --------+-----------+-----------------+---------------+------------------------
//  s_*     | in        | [7:0] in_byte   | -             | -
//  m_*     | out       | [7:0] out_byte  | [1:0] out_kind| last result of a byte
//
// Each raw byte is held in the input register and then decoded into the result
// queue, where its first result word is registered before it can leave. A byte
// is decoded only when the queue has room for two words; with one result per
// byte and a ready sink the block takes a word every cycle. A byte that flushes
// a pending octal or hex value yields two words. Reset (synchronous, rst high)
// empties the queue and the input register and returns to normal text.
// Stalls on the output side fill the queue and then drop s_tready.
module string_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [1:0] out_kind
  output logic       m_tlast
);

  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  // Input register.
  logic       r_valid;
  logic [7:0] r_byte;

  // Decoder state and its combinational successor.
  sed_pkg::state_t st;
  sed_pkg::state_t st_next;
  sed_pkg::dec_t   dec;

  // Result queue.
  sed_pkg::result_t fifo [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic dec_fire;
  logic pop;

  sed_decode u_decode (
    .st      (st),
    .in_byte (r_byte),
    .st_next (st_next),
    .dec     (dec)
  );

  // A byte is decoded only when both possible result words fit.
  assign dec_fire = r_valid && (count <= CNT_W'(OUT_DEPTH - 2));
  assign s_tready = !r_valid || dec_fire;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      r_valid <= 1'b1;
    end else if (dec_fire) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      r_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{mode: sed_pkg::MODE_NORMAL, digit_value: 8'd0, digit_count: 2'd0};
    end else if (dec_fire) begin
      st <= st_next;
    end
  end

  // Queue writes: up to two words at the write pointer.
  always_ff @(posedge clk) begin
    if (dec_fire && dec.count != 2'd0) begin
      fifo[wr_ptr] <= dec.res0;
    end
    if (dec_fire && dec.count == 2'd2) begin
      fifo[wr_ptr + PTR_W'(1)] <= dec.res1;
    end
  end

  assign count_next = count + (dec_fire ? CNT_W'(dec.count) : CNT_W'(0))
                            - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (dec_fire) wr_ptr <= wr_ptr + PTR_W'(dec.count);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

  assign m_tvalid = (count != '0);
  assign m_tdata  = fifo[rd_ptr].data;
  assign m_tuser  = fifo[rd_ptr].kind;
  assign m_tlast  = fifo[rd_ptr].last;

  // The queue never holds more words than it has entries.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(OUT_DEPTH))
    else $error("result queue overflow");

  // A byte that yields two words always leads with the flushed digit value.
  a_pair_first_byte: assert property (@(posedge clk) disable iff (rst)
    (dec_fire && dec.count == 2'd2) |-> (dec.res0.kind == sed_pkg::KIND_BYTE))
    else $error("two-word result does not start with a decoded byte");

  // An end or error result returns the decoder to clean normal text.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (dec_fire && ((dec.count == 2'd1 && dec.res0.kind != sed_pkg::KIND_BYTE) ||
                  (dec.count == 2'd2 && dec.res1.kind != sed_pkg::KIND_BYTE)))
    |=> (st.mode == sed_pkg::MODE_NORMAL && st.digit_count == 2'd0))
    else $error("state not cleared after end or error");

  // Digits are pending only while gathering an octal or a hex escape.
  a_digits_mode: assert property (@(posedge clk) disable iff (rst)
    (st.digit_count != 2'd0) |->
      (st.mode == sed_pkg::MODE_OCT || st.mode == sed_pkg::MODE_HEX1))
    else $error("pending digits outside a numeric escape");

endmodule

// ===== verif/string_escape_decoder_test.sv =====
// Self-checking testbench for string_escape_decoder: raw string-body bytes in, decoded words out.
// A clocked driver and a monitor exchange words with the block, and an in-line decoder predicts
// the results. Depends on sed_pkg and the design top level.
`timescale 1ns / 100ps

module string_escape_decoder_test;

  localparam logic [7:0] NUL       = 8'h00;
  localparam logic [7:0] QUOTE     = 8'h22;
  localparam logic [7:0] BACKSLASH = 8'h5C;

  localparam int unsigned RANDOM_CHUNK = 300;
  localparam int unsigned HOLD_AT      = 200;   // output word count that starts the long hold
  localparam int unsigned HOLD_LEN     = 100;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS  = 10;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;            // [7:0] out_byte
  logic [1:0] m_tuser;            // [1:0] out_kind
  logic       m_tlast;

  string_escape_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // Bytes waiting to be offered, and the decoded words still owed by the block.
  logic [7:0]        raw_bytes[$];
  sed_pkg::result_t  expected_words[$];
  sed_pkg::result_t  step_words[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken  = 0;
  int unsigned words_seen   = 0;
  int unsigned error_count  = 0;

  // Predicted decoder state.
  sed_pkg::mode_t dec_mode  = sed_pkg::MODE_NORMAL;
  logic [7:0]     dec_value = 8'h00;
  logic [1:0]     dec_count = 2'd0;

  // Handshake pacing state, one set per side.
  int unsigned send_wait = 0;
  int unsigned send_run  = 0;
  int unsigned recv_wait = 0;
  int unsigned recv_run  = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  // Mostly short gaps, a few long ones, and now and then a stretch with none at all.
  function automatic int unsigned pick_gap(inout int unsigned run_left);
    int unsigned r;
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  // Bit 8 flags a simple escape letter, bits 7:0 hold the byte it stands for.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    case (c)
      "n":       return {1'b1, 8'h0A};
      "r":       return {1'b1, 8'h0D};
      "t":       return {1'b1, 8'h09};
      "v":       return {1'b1, 8'h0B};
      "a":       return {1'b1, 8'h07};
      "b":       return {1'b1, 8'h08};
      "f":       return {1'b1, 8'h0C};
      "'":       return {1'b1, c};
      QUOTE:     return {1'b1, c};
      BACKSLASH: return {1'b1, c};
      "?":       return {1'b1, c};
      default:   return {1'b0, 8'h00};
    endcase
  endfunction

  task automatic add_word(input sed_pkg::kind_t k, input logic [7:0] b);
    sed_pkg::result_t w;
    w.kind = k;
    w.data = (k == sed_pkg::KIND_BYTE) ? b : 8'h00;
    w.last = 1'b0;
    step_words.push_back(w);
  endtask

  task automatic clear_decoder();
    dec_mode  = sed_pkg::MODE_NORMAL;
    dec_value = 8'h00;
    dec_count = 2'd0;
  endtask

  // A byte seen as plain text: NUL is an error, a quote closes the string.
  task automatic text_byte(input logic [7:0] c);
    if (c == NUL) begin
      clear_decoder();
      add_word(sed_pkg::KIND_ERR, 8'h00);
    end else if (c == QUOTE) begin
      clear_decoder();
      add_word(sed_pkg::KIND_END, 8'h00);
    end else if (c == BACKSLASH) begin
      dec_mode = sed_pkg::MODE_ESC;
    end else begin
      add_word(sed_pkg::KIND_BYTE, c);
    end
  endtask

  // Advance the predicted decoder by one raw byte and queue the words it owes.
  task automatic decode_byte(input logic [7:0] c);
    int               h;
    logic [8:0]       esc;
    sed_pkg::result_t w;
    step_words.delete();
    h   = hex_value(c);
    esc = simple_escape(c);
    case (dec_mode)
      sed_pkg::MODE_ESC: begin
        clear_decoder();
        if (c == NUL) begin
          add_word(sed_pkg::KIND_ERR, 8'h00);
        end else if (esc[8]) begin
          add_word(sed_pkg::KIND_BYTE, esc[7:0]);
        end else if (c == "0") begin
          // Digits after a zero escape are plain text.
          add_word(sed_pkg::KIND_BYTE, 8'h00);
        end else if (c >= "1" && c <= "7") begin
          dec_mode  = sed_pkg::MODE_OCT;
          dec_value = {5'd0, c[2:0]};
          dec_count = 2'd1;
        end else if (c == "x") begin
          dec_mode = sed_pkg::MODE_HEX0;
        end else begin
          add_word(sed_pkg::KIND_BYTE, c);
        end
      end
      sed_pkg::MODE_OCT: begin
        if (c >= "0" && c <= "7") begin
          // Shifting out the top bits keeps only the low byte of a large octal value.
          dec_value = {dec_value[4:0], c[2:0]};
          dec_count = dec_count + 2'd1;
          if (dec_count == 2'd3) begin
            add_word(sed_pkg::KIND_BYTE, dec_value);
            clear_decoder();
          end
        end else begin
          add_word(sed_pkg::KIND_BYTE, dec_value);
          clear_decoder();
          text_byte(c);
        end
      end
      sed_pkg::MODE_HEX0: begin
        if (h < 0) begin
          clear_decoder();
          add_word(sed_pkg::KIND_ERR, 8'h00);
        end else begin
          dec_mode  = sed_pkg::MODE_HEX1;
          dec_value = 8'(h);
          dec_count = 2'd1;
        end
      end
      sed_pkg::MODE_HEX1: begin
        if (h >= 0) begin
          add_word(sed_pkg::KIND_BYTE, {dec_value[3:0], 4'(h)});
          clear_decoder();
        end else begin
          add_word(sed_pkg::KIND_BYTE, dec_value);
          clear_decoder();
          text_byte(c);
        end
      end
      default: begin
        clear_decoder();
        text_byte(c);
      end
    endcase
    if (step_words.size() > 0) begin
      w = step_words[step_words.size() - 1];
      w.last = 1'b1;
      step_words[step_words.size() - 1] = w;
    end
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endtask

  // Driver: offers queued bytes, predicts each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      send_wait = 0;
      clear_decoder();
    end else begin
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata);
        bytes_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_tvalid <= 1'b0;
        end else if (raw_bytes.size() > 0) begin
          s_tdata  <= raw_bytes.pop_front();
          s_tvalid <= 1'b1;
          send_wait = pick_gap(send_run);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each word against the oldest prediction and paces m_tready.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected word: kind %0d byte %h last %b", m_tuser, m_tdata, m_tlast);
        end else begin
          sed_pkg::result_t w;
          w = expected_words.pop_front();
          if (sed_pkg::kind_t'(m_tuser) != w.kind || m_tdata != w.data || m_tlast != w.last)
          begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("word %0d: expected kind %0d byte %h last %b, got kind %0d byte %h last %b",
                       words_seen, w.kind, w.data, w.last, m_tuser, m_tdata, m_tlast);
          end
        end
        words_seen++;
        // One long hold-off mid-run lets the block fill up and push back on its input.
        if (words_seen == HOLD_AT) hold_left = HOLD_LEN;
        else recv_wait = pick_gap(recv_run);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too many cycles without any word moving on either side ends the run.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("string_escape_decoder: mismatch");
      $finish;
    end
  end

  task automatic push_raw(input logic [7:0] b);
    raw_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_raw(s[i]);
  endtask

  // Sender pause: nothing new is offered until every predicted word has come out.
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || expected_words.size() != 0) @(posedge clk);
  endtask

  // One random token; most are well-formed escapes or text, the rest is noise.
  task automatic gen_token();
    string       esc_chars;
    string       hex_chars;
    int unsigned r;
    int unsigned n;
    logic [7:0]  b;
    esc_chars = "nrtvabf'\"\\?";
    hex_chars = "0123456789ABCDEFabcdef";
    r = $urandom_range(0, 99);
    if (r < 30) begin
      b = 8'($urandom_range(1, 255));
      if (b == QUOTE || b == BACKSLASH) b = b + 8'd1;
      push_raw(b);
    end else if (r < 42) begin
      push_raw(BACKSLASH);
      push_raw(esc_chars[$urandom_range(0, 10)]);
    end else if (r < 47) begin
      push_raw(BACKSLASH);
      push_raw("0");
      if ($urandom_range(0, 1)) push_raw(8'("0" + $urandom_range(0, 9)));
    end else if (r < 60) begin
      push_raw(BACKSLASH);
      push_raw(8'("1" + $urandom_range(0, 6)));
      n = $urandom_range(0, 2);
      repeat (n) push_raw(8'("0" + $urandom_range(0, 7)));
    end else if (r < 72) begin
      push_raw(BACKSLASH);
      push_raw("x");
      n = $urandom_range(1, 2);
      repeat (n) push_raw(hex_chars[$urandom_range(0, 21)]);
    end else if (r < 75) begin
      push_raw(BACKSLASH);
      push_raw("x");
      b = 8'($urandom_range(0, 255));
      if (hex_value(b) >= 0) b = "z";
      push_raw(b);
    end else if (r < 80) begin
      push_raw(BACKSLASH);
      push_raw(8'($urandom_range(0, 255)));
    end else if (r < 86) begin
      push_raw(QUOTE);
    end else if (r < 89) begin
      push_raw(NUL);
    end else begin
      push_raw(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero escape with a literal digit after it, octal overflow, hex of two
    // digits, hex flushed by a letter, bad hex, octal flushed by NUL, NUL after a
    // backslash, top byte value, closing quote, bare NUL.
    push_text("\\01");
    push_text("\\777");
    push_text("\\x41");
    push_text("\\xFz");
    push_text("\\xg");
    push_text("\\12");
    push_raw(NUL);
    push_raw(BACKSLASH);
    push_raw(NUL);
    push_raw(8'hFF);
    push_raw(QUOTE);
    push_raw(NUL);
    wait_drained();

    repeat (2) begin
      target = bytes_queued + RANDOM_CHUNK;
      while (bytes_queued < target) gen_token();
      wait_drained();
    end

    // Give a stray extra word time to show up.
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("string_escape_decoder: match");
    end else begin
      $display("string_escape_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sed_pkg.sv
design/sed_decode.sv
design/string_escape_decoder.sv
verif/string_escape_decoder_test.sv
